// ----- rtl/tchd_pkg.sv -----
package tchd_pkg;

    // Per-byte verdict codes, also used as the sticky final verdict.
    typedef enum logic [1:0] {
        ST_INCOMPLETE = 2'd0,
        ST_HDR_READY  = 2'd1,
        ST_COMPLETE   = 2'd2,
        ST_NOT_HELLO  = 2'd3
    } status_t;

    // One result transfer.
    typedef struct packed {
        logic [16:0] hello_length;
        logic [14:0] bytes_needed;
        status_t     status;
    } tchd_result_t;

    localparam logic [7:0]  REC_TYPE_HANDSHAKE = 8'd22;
    localparam logic [7:0]  REC_VER_MAJOR      = 8'd3;
    localparam logic [7:0]  REC_VER_MINOR_LO   = 8'd1;
    localparam logic [7:0]  REC_VER_MINOR_HI   = 8'd3;
    localparam logic [15:0] REC_LEN_MAX        = 16'd16384;
    localparam logic [2:0]  REC_HDR_LEN        = 3'd5;
    localparam logic [7:0]  HS_TYPE_HELLO      = 8'd1;
    localparam logic [2:0]  HS_HDR_LEN         = 3'd4;
    localparam logic [23:0] HS_BODY_MIN        = 24'd41;
    localparam logic [16:0] MAX_HELLO_RESET    = 17'd16384;

endpackage

// ----- rtl/tchd_core.sv -----
module tchd_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step_en,
    input  logic [7:0]            data_byte,
    input  logic                  restart,
    input  logic [16:0]           max_hello_size,
    output tchd_pkg::tchd_result_t result
);
    import tchd_pkg::*;

    logic [2:0]  rec_hdr_cnt_reg,  rec_hdr_cnt_next;
    logic [7:0]  rec_len_hi_reg,   rec_len_hi_next;
    logic [14:0] rec_left_reg,     rec_left_next;
    logic [2:0]  hs_hdr_cnt_reg,   hs_hdr_cnt_next;
    logic [15:0] hs_len_bytes_reg, hs_len_bytes_next;
    logic [16:0] hs_seen_reg,      hs_seen_next;
    logic [16:0] hs_total_reg,     hs_total_next;
    status_t     verdict_reg,      verdict_next;

    // Parse one byte: start from the current state, cleared on restart.
    always_comb begin
        logic [2:0]  rhc;
        logic [14:0] rl;
        logic [2:0]  hhc;
        logic [15:0] hlb;
        logic [16:0] seen;
        logic [16:0] total;
        status_t     verdict;
        logic [15:0] rec_body;
        logic [23:0] hs_body;
        logic [24:0] hs_size;
        logic [14:0] rl_dec;
        logic [16:0] seen_inc;
        logic [16:0] body_left;
        logic [16:0] want;
        status_t     status;

        rhc     = restart ? '0 : rec_hdr_cnt_reg;
        rl      = restart ? '0 : rec_left_reg;
        hhc     = restart ? '0 : hs_hdr_cnt_reg;
        hlb     = restart ? '0 : hs_len_bytes_reg;
        seen    = restart ? '0 : hs_seen_reg;
        total   = restart ? '0 : hs_total_reg;
        verdict = restart ? ST_INCOMPLETE : verdict_reg;

        rec_hdr_cnt_next  = rhc;
        rec_len_hi_next   = restart ? '0 : rec_len_hi_reg;
        rec_left_next     = rl;
        hs_hdr_cnt_next   = hhc;
        hs_len_bytes_next = hlb;
        hs_seen_next      = seen;
        hs_total_next     = total;
        verdict_next      = verdict;

        rec_body  = {rec_len_hi_next, data_byte};
        hs_body   = '0;
        hs_size   = '0;
        rl_dec    = rl - 15'd1;
        seen_inc  = seen + 17'd1;
        body_left = '0;
        want      = '0;
        status    = ST_INCOMPLETE;

        if (verdict != ST_INCOMPLETE) begin
            status = verdict;
        end else if (rhc < REC_HDR_LEN) begin
            // Record header: type, version, then a 16-bit length.
            case (rhc)
                3'd0: if (data_byte != REC_TYPE_HANDSHAKE) status = ST_NOT_HELLO;
                3'd1: if (data_byte != REC_VER_MAJOR) status = ST_NOT_HELLO;
                3'd2: begin
                    if (data_byte < REC_VER_MINOR_LO || data_byte > REC_VER_MINOR_HI)
                        status = ST_NOT_HELLO;
                end
                3'd3: rec_len_hi_next = data_byte;
                default: begin
                    if (rec_body == '0 || rec_body > REC_LEN_MAX)
                        status = ST_NOT_HELLO;
                    else
                        rec_left_next = rec_body[14:0];
                end
            endcase
            if (status == ST_INCOMPLETE)
                rec_hdr_cnt_next = rhc + 3'd1;
        end else begin
            rec_left_next = rl_dec;
            hs_seen_next  = seen_inc;
            if (hhc < HS_HDR_LEN) begin
                // Handshake header: type byte, then a 24-bit body length.
                if (hhc == 3'd0) begin
                    if (data_byte != HS_TYPE_HELLO)
                        status = ST_NOT_HELLO;
                end else if (hhc < 3'd3) begin
                    hs_len_bytes_next = {hlb[7:0], data_byte};
                end else begin
                    hs_body = {hlb, data_byte};
                end
                if (status == ST_INCOMPLETE) begin
                    hs_hdr_cnt_next = hhc + 3'd1;
                    if (rl_dec == '0)
                        rec_hdr_cnt_next = '0;
                    if (hhc == 3'd3) begin
                        hs_size = {1'b0, hs_body} + 25'd4;
                        if (hs_body < HS_BODY_MIN || hs_size > {8'b0, max_hello_size}) begin
                            status = ST_NOT_HELLO;
                        end else begin
                            hs_total_next = hs_size[16:0];
                            status        = ST_HDR_READY;
                        end
                    end
                end
            end else if (seen_inc == total) begin
                // Last hello byte must also close the record.
                status = (rl_dec == '0) ? ST_COMPLETE : ST_NOT_HELLO;
            end else if (rl_dec == '0) begin
                rec_hdr_cnt_next = '0;
            end
        end

        if (status == ST_COMPLETE || status == ST_NOT_HELLO)
            verdict_next = status;

        // Bytes wanted before the next decision, from the updated state.
        if (hs_seen_next < hs_total_next)
            body_left = hs_total_next - hs_seen_next;
        if (verdict_next != ST_INCOMPLETE) begin
            want = '0;
        end else if (rec_hdr_cnt_next < REC_HDR_LEN) begin
            want = {14'b0, REC_HDR_LEN - rec_hdr_cnt_next};
        end else if (hs_hdr_cnt_next < HS_HDR_LEN) begin
            want = {14'b0, HS_HDR_LEN - hs_hdr_cnt_next};
            if ({2'b0, rec_left_next} < want)
                want = {2'b0, rec_left_next};
        end else begin
            want = body_left;
            if ({2'b0, rec_left_next} < want)
                want = {2'b0, rec_left_next};
        end

        result.status       = status;
        result.bytes_needed = want[14:0];
        result.hello_length = hs_total_next;
    end

    // Parse state advances once per processed byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_hdr_cnt_reg  <= '0;
            rec_len_hi_reg   <= '0;
            rec_left_reg     <= '0;
            hs_hdr_cnt_reg   <= '0;
            hs_len_bytes_reg <= '0;
            hs_seen_reg      <= '0;
            hs_total_reg     <= '0;
            verdict_reg      <= ST_INCOMPLETE;
        end else if (step_en) begin
            rec_hdr_cnt_reg  <= rec_hdr_cnt_next;
            rec_len_hi_reg   <= rec_len_hi_next;
            rec_left_reg     <= rec_left_next;
            hs_hdr_cnt_reg   <= hs_hdr_cnt_next;
            hs_len_bytes_reg <= hs_len_bytes_next;
            hs_seen_reg      <= hs_seen_next;
            hs_total_reg     <= hs_total_next;
            verdict_reg      <= verdict_next;
        end
    end

endmodule

// ----- rtl/tls_client_hello_detector_unit.sv -----
// Path: a byte accepted into the input register goes through the parse logic into the output
// register, which presents its result on m_axis while the output side is not stalled.
// Throughput: one byte per cycle; the input register, the parse logic and the output
// register form a two-stage pipeline that stalls only when the output register is held.
// Reset: aresetn low at a clock edge clears all parse state and both pipeline stages, and
// sets max_hello_size to 16384.
module tls_client_hello_detector_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [16:0] cfg_wr_data,     // max_hello_size
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] data_byte
    input  logic        s_axis_tuser,    // [0] restart
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata     // [1:0] status, [16:2] bytes_needed,
                                         // [33:17] hello_length, [39:34] zero
);
    import tchd_pkg::*;

    logic [16:0]  max_hello_size_reg;
    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_restart_reg;
    logic         out_valid_reg;
    tchd_result_t out_result_reg;
    tchd_result_t step_result;
    logic         advance;
    logic         step_en;

    // The pipeline moves whenever the output register is empty or being drained.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign step_en       = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_hello_size_reg <= MAX_HELLO_RESET;
        end else if (cfg_wr_en) begin
            max_hello_size_reg <= cfg_wr_data;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_byte_reg    <= s_axis_tdata;
            in_restart_reg <= s_axis_tuser;
        end
    end

    tchd_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step_en        (step_en),
        .data_byte      (in_byte_reg),
        .restart        (in_restart_reg),
        .max_hello_size (max_hello_size_reg),
        .result         (step_result)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            out_result_reg <= step_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_result_reg.hello_length,
                            out_result_reg.bytes_needed, out_result_reg.status};

    // An empty output register never blocks the input side.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output register is empty");

    // A final verdict asks for no more bytes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (out_result_reg.status == ST_COMPLETE ||
                           out_result_reg.status == ST_NOT_HELLO))
        |-> (out_result_reg.bytes_needed == '0))
        else $error("final verdict with bytes still needed");

    // An accepted handshake header always reports a hello length of at least 45.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && out_result_reg.status == ST_HDR_READY)
        |-> (out_result_reg.hello_length >= 17'd45))
        else $error("header ready without a valid hello length");

    // A processed byte always lands in the output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_en |=> out_valid_reg)
        else $error("processed byte lost");

endmodule

// ----- tb/tls_client_hello_detector_unit_tb.sv -----
`timescale 1ns / 1ps

module tls_client_hello_detector_unit_tb;
    import tchd_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 7;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 300;
    localparam int CFG_SETTLE   = 4;
    localparam int TAIL_CYCLES  = 20;

    // One stream byte to offer, with an optional hand-written expectation.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        restart;
        logic        known;
        status_t     want_status;
        logic [14:0] want_needed;
        logic [16:0] want_len;
    } stim_item_t;

    // Shapes of byte sequences that the random part builds.
    typedef enum int {
        SEQ_GOOD,
        SEQ_BAD_TYPE,
        SEQ_BAD_MAJOR,
        SEQ_BAD_MINOR,
        SEQ_BAD_REC_LEN,
        SEQ_BAD_HS_TYPE,
        SEQ_SHORT_BODY,
        SEQ_LONG_BODY,
        SEQ_TAIL_IN_RECORD,
        SEQ_SIZE_EDGE,
        SEQ_CUT,
        SEQ_NOISE
    } seq_kind_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [16:0] cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;

    stim_item_t   byte_q[$];
    tchd_result_t verdict_q[$];
    int           n_queued = 0;
    int           n_checked = 0;
    int           errors = 0;
    int           cycle_cnt = 0;
    bit           idle_on = 1'b0;
    bit           hold_req = 1'b0;

    // Parser state as the testbench tracks it.
    logic [16:0] p_max_hello;
    logic [2:0]  p_rec_hdr_cnt;
    logic [7:0]  p_rec_len_hi;
    logic [14:0] p_rec_left;
    logic [2:0]  p_hs_hdr_cnt;
    logic [15:0] p_hs_len_hi;
    logic [16:0] p_hs_seen;
    logic [16:0] p_total;
    status_t     p_verdict;

    // Record header errors and extremes after reset, with the register at 16384.
    localparam stim_item_t DIRECTED_ROWS [25] = '{
        '{8'h00, 1'b0, 1'b1, ST_NOT_HELLO,  15'd0, 17'd0},
        '{8'hFF, 1'b0, 1'b1, ST_NOT_HELLO,  15'd0, 17'd0},
        '{8'h16, 1'b1, 1'b1, ST_INCOMPLETE, 15'd4, 17'd0},
        '{8'h03, 1'b0, 1'b1, ST_INCOMPLETE, 15'd3, 17'd0},
        '{8'h03, 1'b0, 1'b1, ST_INCOMPLETE, 15'd2, 17'd0},
        '{8'h40, 1'b0, 1'b1, ST_INCOMPLETE, 15'd1, 17'd0},
        '{8'h00, 1'b0, 1'b1, ST_INCOMPLETE, 15'd4, 17'd0},
        '{8'h01, 1'b0, 1'b0, ST_INCOMPLETE, 15'd0, 17'd0},
        '{8'hFF, 1'b0, 1'b0, ST_INCOMPLETE, 15'd0, 17'd0},
        '{8'hFF, 1'b0, 1'b0, ST_INCOMPLETE, 15'd0, 17'd0},
        '{8'hFF, 1'b0, 1'b1, ST_NOT_HELLO,  15'd0, 17'd0},
        '{8'h16, 1'b1, 1'b1, ST_INCOMPLETE, 15'd4, 17'd0},
        '{8'h03, 1'b0, 1'b1, ST_INCOMPLETE, 15'd3, 17'd0},
        '{8'h01, 1'b0, 1'b1, ST_INCOMPLETE, 15'd2, 17'd0},
        '{8'h40, 1'b0, 1'b1, ST_INCOMPLETE, 15'd1, 17'd0},
        '{8'h01, 1'b0, 1'b1, ST_NOT_HELLO,  15'd0, 17'd0},
        '{8'h16, 1'b1, 1'b1, ST_INCOMPLETE, 15'd4, 17'd0},
        '{8'h03, 1'b0, 1'b1, ST_INCOMPLETE, 15'd3, 17'd0},
        '{8'h00, 1'b0, 1'b1, ST_NOT_HELLO,  15'd0, 17'd0},
        '{8'h16, 1'b1, 1'b1, ST_INCOMPLETE, 15'd4, 17'd0},
        '{8'h02, 1'b0, 1'b1, ST_NOT_HELLO,  15'd0, 17'd0},
        '{8'h17, 1'b1, 1'b1, ST_NOT_HELLO,  15'd0, 17'd0},
        '{8'h16, 1'b1, 1'b1, ST_INCOMPLETE, 15'd4, 17'd0},
        '{8'h03, 1'b0, 1'b1, ST_INCOMPLETE, 15'd3, 17'd0},
        '{8'h04, 1'b0, 1'b1, ST_NOT_HELLO,  15'd0, 17'd0}
    };

    tls_client_hello_detector_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Free-running clock.
    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Run limit in case the block stops moving.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic void clear_parse();
        p_rec_hdr_cnt = '0;
        p_rec_len_hi  = '0;
        p_rec_left    = '0;
        p_hs_hdr_cnt  = '0;
        p_hs_len_hi   = '0;
        p_hs_seen     = '0;
        p_total       = '0;
        p_verdict     = ST_INCOMPLETE;
    endfunction

    // Bytes still wanted before the parser can decide anything new.
    function automatic logic [14:0] wanted_bytes();
        int unsigned left;
        if (p_verdict != ST_INCOMPLETE)
            return '0;
        if (p_rec_hdr_cnt < REC_HDR_LEN)
            return 15'(REC_HDR_LEN - p_rec_hdr_cnt);
        if (p_hs_hdr_cnt < HS_HDR_LEN)
            left = HS_HDR_LEN - p_hs_hdr_cnt;
        else
            left = (p_hs_seen < p_total) ? p_total - p_hs_seen : 0;
        return (p_rec_left < left) ? p_rec_left : 15'(left);
    endfunction

    // Consumes one byte while no verdict is held and returns its status.
    function automatic status_t take_byte(logic [7:0] b);
        int unsigned len_val;
        if (p_rec_hdr_cnt < REC_HDR_LEN) begin
            case (p_rec_hdr_cnt)
                0: if (b != REC_TYPE_HANDSHAKE) return ST_NOT_HELLO;
                1: if (b != REC_VER_MAJOR) return ST_NOT_HELLO;
                2: if (b < REC_VER_MINOR_LO || b > REC_VER_MINOR_HI) return ST_NOT_HELLO;
                3: p_rec_len_hi = b;
                default: begin
                    len_val = {p_rec_len_hi, b};
                    if (len_val == 0 || len_val > REC_LEN_MAX)
                        return ST_NOT_HELLO;
                    p_rec_left = len_val[14:0];
                end
            endcase
            p_rec_hdr_cnt = p_rec_hdr_cnt + 1'b1;
            return ST_INCOMPLETE;
        end

        // Payload byte: it belongs to the handshake message.
        p_rec_left = p_rec_left - 1'b1;
        p_hs_seen  = p_hs_seen + 1'b1;

        if (p_hs_hdr_cnt < HS_HDR_LEN) begin
            len_val = 0;
            if (p_hs_hdr_cnt == 0) begin
                if (b != HS_TYPE_HELLO)
                    return ST_NOT_HELLO;
            end else if (p_hs_hdr_cnt < 3) begin
                p_hs_len_hi = {p_hs_len_hi[7:0], b};
            end else begin
                len_val = {p_hs_len_hi, b};
            end
            p_hs_hdr_cnt = p_hs_hdr_cnt + 1'b1;
            if (p_rec_left == 0)
                p_rec_hdr_cnt = '0;
            if (p_hs_hdr_cnt == HS_HDR_LEN) begin
                if (len_val < HS_BODY_MIN || len_val + HS_HDR_LEN > p_max_hello)
                    return ST_NOT_HELLO;
                p_total = 17'(len_val + HS_HDR_LEN);
                return ST_HDR_READY;
            end
            return ST_INCOMPLETE;
        end

        // The hello must end exactly on a record boundary.
        if (p_hs_seen == p_total)
            return (p_rec_left == 0) ? ST_COMPLETE : ST_NOT_HELLO;
        if (p_rec_left == 0)
            p_rec_hdr_cnt = '0;
        return ST_INCOMPLETE;
    endfunction

    function automatic tchd_result_t predict_result(logic [7:0] b, logic restart);
        tchd_result_t r;
        status_t      st;
        if (restart)
            clear_parse();
        if (p_verdict != ST_INCOMPLETE) begin
            st = p_verdict;
        end else begin
            st = take_byte(b);
            if (st == ST_COMPLETE || st == ST_NOT_HELLO)
                p_verdict = st;
        end
        r.status       = st;
        r.bytes_needed = wanted_bytes();
        r.hello_length = p_total;
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(25, 70);
    endfunction

    function automatic logic [7:0] pick_other(logic [7:0] avoid);
        logic [7:0] v;
        v = 8'($urandom);
        if (v == avoid)
            v = avoid + 1'b1;
        return v;
    endfunction

    // Handshake message byte at a given offset.
    function automatic logic [7:0] hs_byte(seq_kind_t kind, logic [23:0] body, int pos);
        case (pos)
            0: return (kind == SEQ_BAD_HS_TYPE) ? pick_other(HS_TYPE_HELLO) : HS_TYPE_HELLO;
            1: return body[23:16];
            2: return body[15:8];
            3: return body[7:0];
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic push_item(stim_item_t it);
        byte_q.push_back(it);
        n_queued++;
    endtask

    task automatic push_byte(logic [7:0] b, logic restart);
        stim_item_t it;
        it           = '0;
        it.data_byte = b;
        it.restart   = restart;
        push_item(it);
    endtask

    task automatic drain_results();
        while (n_checked < n_queued)
            @(posedge aclk);
    endtask

    // Register write with the block idle.
    task automatic set_max_hello(logic [16:0] value);
        drain_results();
        repeat (CFG_SETTLE) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        p_max_hello = value;
    endtask

    // Builds one stream opening: a hello split over records, possibly broken.
    task automatic emit_sequence();
        seq_kind_t  kind;
        int         body, total, rem, reclen, hdr_len, lim, cap, stop_at;
        int         hs_pos, rec_idx, bad_rec, n;
        logic [7:0] ctype, ver_major, minor;
        logic       first, corrupt;

        if ($urandom_range(0, 99) < 55)
            kind = SEQ_GOOD;
        else
            kind = seq_kind_t'($urandom_range(1, SEQ_NOISE));

        // Plain noise with the odd restart inside.
        if (kind == SEQ_NOISE) begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++)
                push_byte(8'($urandom), (i == 0) ? 1'b1 : ($urandom_range(0, 7) == 0));
            return;
        end

        // Body length: small most of the time, within the register limit.
        lim = int'(p_max_hello) - int'(HS_HDR_LEN) - int'(HS_BODY_MIN);
        if (lim < 0)
            lim = 0;
        cap = ($urandom_range(0, 9) == 0) ? 500 : 80;
        if (cap > lim)
            cap = lim;
        body = int'(HS_BODY_MIN) + $urandom_range(0, cap);
        case (kind)
            SEQ_SHORT_BODY: body = $urandom_range(0, 40);
            SEQ_LONG_BODY:  body = ($urandom_range(0, 3) == 0) ? 24'hFFFFFF :
                                   int'(p_max_hello) - 3 + $urandom_range(0, 3);
            SEQ_SIZE_EDGE:  body = int'(p_max_hello) - int'(HS_HDR_LEN);
            default: ;
        endcase
        total = body + HS_HDR_LEN;

        // Size probes stop shortly after the handshake header.
        stop_at = total;
        if (kind == SEQ_SHORT_BODY || kind == SEQ_LONG_BODY || kind == SEQ_SIZE_EDGE)
            stop_at = HS_HDR_LEN + $urandom_range(0, 6);
        if (kind == SEQ_CUT)
            stop_at = $urandom_range(1, total - 1);

        bad_rec = $urandom_range(0, 2);
        rem     = total;
        hs_pos  = 0;
        rec_idx = 0;
        first   = 1'b1;
        while (rem > 0 && hs_pos < stop_at) begin
            case ($urandom_range(0, 3))
                0, 1:    reclen = rem;
                2:       reclen = $urandom_range(1, rem);
                default: reclen = $urandom_range(1, (rem < 6) ? rem : 6);
            endcase
            if (reclen > REC_LEN_MAX)
                reclen = REC_LEN_MAX;
            // The last record runs past the end of the hello.
            if (kind == SEQ_TAIL_IN_RECORD && reclen == rem)
                reclen = rem + $urandom_range(1, 5);

            ctype     = REC_TYPE_HANDSHAKE;
            ver_major = REC_VER_MAJOR;
            minor     = 8'($urandom_range(REC_VER_MINOR_LO, REC_VER_MINOR_HI));
            hdr_len   = reclen;
            corrupt   = (rec_idx == bad_rec);
            if (corrupt) begin
                case (kind)
                    SEQ_BAD_TYPE:    ctype = pick_other(REC_TYPE_HANDSHAKE);
                    SEQ_BAD_MAJOR:   ver_major = pick_other(REC_VER_MAJOR);
                    SEQ_BAD_MINOR:   minor = ($urandom_range(0, 1) == 0) ? 8'd0 :
                                             8'($urandom_range(4, 255));
                    SEQ_BAD_REC_LEN: hdr_len = ($urandom_range(0, 1) == 0) ? 0 :
                                               $urandom_range(16385, 65535);
                    default:         corrupt = 1'b0;
                endcase
            end

            push_byte(ctype, first);
            first = 1'b0;
            push_byte(ver_major, 1'b0);
            push_byte(minor, 1'b0);
            push_byte(8'(hdr_len >> 8), 1'b0);
            push_byte(8'(hdr_len), 1'b0);

            // After a bad record header only a few ignored bytes follow.
            if (corrupt && reclen > 4)
                reclen = 4;
            for (int i = 0; i < reclen && hs_pos < stop_at; i++) begin
                push_byte(hs_byte(kind, 24'(body), hs_pos), 1'b0);
                hs_pos++;
            end
            if (corrupt)
                break;
            rem = (reclen >= rem) ? 0 : rem - reclen;
            rec_idx++;
        end

        // Trailing bytes land on the held verdict or keep parsing.
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++)
            push_byte(8'($urandom), 1'b0);
    endtask

    task automatic run_random(int budget);
        int start;
        start = n_queued;
        while (n_queued - start < budget)
            emit_sequence();
    endtask

    // Input side: offers queued bytes and predicts each accepted transfer.
    initial begin : byte_sender
        stim_item_t   it;
        tchd_result_t want;
        forever begin
            if (byte_q.size() == 0) begin
                if (s_axis_tvalid)
                    s_axis_tvalid <= 1'b0;
                @(posedge aclk);
            end else begin
                if (idle_on && $urandom_range(0, 2) == 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat (pick_gap()) @(posedge aclk);
                end
                it = byte_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= it.data_byte;
                s_axis_tuser  <= it.restart;
                do
                    @(negedge aclk);
                while (!s_axis_tready);
                @(posedge aclk);
                want = predict_result(it.data_byte, it.restart);
                if (it.known)
                    want = '{hello_length: it.want_len,
                             bytes_needed: it.want_needed,
                             status: it.want_status};
                verdict_q.push_back(want);
            end
        end
    end

    // Output side: random stalls, plus one long hold-off on request.
    initial begin : result_sink
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
                m_axis_tready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat (pick_gap()) @(posedge aclk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // A transfer seen high at the falling edge completes at the next rising edge.
    always @(negedge aclk) begin : result_check
        tchd_result_t got;
        tchd_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[33:0];
            if (verdict_q.size() == 0) begin
                $error("result transfer with nothing expected: tdata %h", m_axis_tdata);
                errors++;
            end else begin
                want = verdict_q.pop_front();
                n_checked++;
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    errors++;
                end
                if (got.bytes_needed !== want.bytes_needed) begin
                    $error("bytes_needed: expected %0d, got %0d",
                           want.bytes_needed, got.bytes_needed);
                    errors++;
                end
                if (got.hello_length !== want.hello_length) begin
                    $error("hello_length: expected %0d, got %0d",
                           want.hello_length, got.hello_length);
                    errors++;
                end
            end
        end
    end

    // Reset, directed table, then random phases over several register values.
    initial begin : main_flow
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        p_max_hello   = MAX_HELLO_RESET;
        clear_parse();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED_ROWS[i])
            push_item(DIRECTED_ROWS[i]);
        drain_results();

        // Smallest legal size: only a 41-byte body passes.
        set_max_hello(17'd45);
        idle_on = 1'b1;
        run_random(330);

        // Size 65536, back to back with no idling.
        set_max_hello(17'd65536);
        idle_on = 1'b0;
        run_random(300);

        // Below the minimum every hello is rejected.
        set_max_hello(17'd44);
        idle_on = 1'b1;
        run_random(120);

        // Output held off for a long stretch while bytes keep coming.
        set_max_hello(17'd65535);
        hold_req = 1'b1;
        run_random(400);

        // Reset value again, with a full pause of the sender midway.
        set_max_hello(MAX_HELLO_RESET);
        run_random(200);
        drain_results();
        run_random(230);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
